>>> rtl/bcp_pkg.sv
// Shared widths, types and register codes for the Bezier curve point evaluator.
// No dependencies; every other file in the block imports this package.
package bcp_pkg;

    localparam int COORD_W  = 16;
    localparam int FRAC_W   = 16;
    localparam int POS_W    = FRAC_W + 1;
    localparam int NUM_AXES = 3;
    localparam int PACKED_W = NUM_AXES * COORD_W;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = DIFF_W + POS_W + 1;
    localparam int CFG_IDX_W = 3;

    // One input register, then two stages for each of the three lerp levels.
    localparam int PIPE_DEPTH = 7;
    localparam int T_TAPS     = 5;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic [POS_W-1:0]          pos_t;
    typedef logic [PACKED_W-1:0]       packed_pt_t;

    localparam pos_t  POS_ONE    = pos_t'(1) << FRAC_W;
    localparam prod_t ROUND_HALF = prod_t'(1) << (FRAC_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEGREE = 3'd0,
        CFG_START  = 3'd1,
        CFG_CTRL1  = 3'd2,
        CFG_CTRL2  = 3'd3,
        CFG_END    = 3'd4
    } cfg_idx_t;

endpackage

>>> rtl/bcp_lerp.sv
// Two-stage fixed-point linear interpolation of one coordinate.
// Depends on bcp_pkg for widths and the rounding constant.
module bcp_lerp (
    input  logic            clk,
    input  logic            en,
    input  bcp_pkg::coord_t a,
    input  bcp_pkg::coord_t b,
    input  bcp_pkg::pos_t   t,
    output bcp_pkg::coord_t res
);
    import bcp_pkg::*;

    diff_t  diff;
    prod_t  prod_next;
    prod_t  prod_reg;
    coord_t a_reg;
    prod_t  rounded;
    prod_t  shifted;
    diff_t  sum;
    coord_t res_next;
    coord_t res_reg;

    // First stage: difference and product.
    always_comb
    begin
        diff      = diff_t'(b) - diff_t'(a);
        prod_next = prod_t'(diff) * prod_t'($signed({1'b0, t}));
    end

    // Second stage: round half up, floor by the arithmetic shift, add the base.
    always_comb
    begin
        rounded  = prod_reg + ROUND_HALF;
        shifted  = rounded >>> FRAC_W;
        sum      = diff_t'(a_reg) + shifted[DIFF_W-1:0];
        res_next = sum[COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            a_reg    <= a;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/bezier_curve_point_core.sv
// Bezier curve point evaluator (quadratic or cubic, 3D) by de Casteljau.
// Throughput one word per cycle while the output word is not held.
// The depth is one input register plus two stages for each of three lerp levels.
// A stalled output word holds the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) empties the pipeline and sets a cubic curve
// with all control points at the origin.
module bezier_curve_point_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [bcp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bcp_pkg::PACKED_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bcp_pkg::pos_t                       position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output bcp_pkg::coord_t                     point_x,
    output bcp_pkg::coord_t                     point_y,
    output bcp_pkg::coord_t                     point_z
);
    import bcp_pkg::*;

    logic       degree_reg;
    packed_pt_t start_reg;
    packed_pt_t ctrl1_reg;
    packed_pt_t ctrl2_reg;
    packed_pt_t end_reg;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic                  en;
    pos_t                  t_sat;
    pos_t                  t_reg [T_TAPS];

    coord_t q01 [NUM_AXES];
    coord_t q12 [NUM_AXES];
    coord_t q23 [NUM_AXES];
    coord_t la  [NUM_AXES];
    coord_t lb  [NUM_AXES];
    coord_t pt  [NUM_AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= 1'b1;
            start_reg  <= '0;
            ctrl1_reg  <= '0;
            ctrl2_reg  <= '0;
            end_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DEGREE: degree_reg <= cfg_data[0];
                CFG_START:  start_reg  <= cfg_data;
                CFG_CTRL1:  ctrl1_reg  <= cfg_data;
                CFG_CTRL2:  ctrl2_reg  <= cfg_data;
                CFG_END:    end_reg    <= cfg_data;
                default:    ;
            endcase
        end
    end

    // The pipeline moves as one; it only halts when the output word is held.
    assign en       = !valid_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready = en;
    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    assign t_sat = (position > POS_ONE) ? POS_ONE : position;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= t_sat;
            for (int i = 1; i < T_TAPS; i++)
            begin
                t_reg[i] <= t_reg[i-1];
            end
        end
    end

    for (genvar c = 0; c < NUM_AXES; c++)
    begin : g_axis
        coord_t p0;
        coord_t p1;
        coord_t p2;
        coord_t p3;
        coord_t b12;
        coord_t b_a;
        coord_t b_b;

        assign p0 = start_reg[c*COORD_W +: COORD_W];
        assign p1 = ctrl1_reg[c*COORD_W +: COORD_W];
        assign p2 = ctrl2_reg[c*COORD_W +: COORD_W];
        assign p3 = end_reg[c*COORD_W +: COORD_W];

        // For a quadratic curve the second point pairs with the end point, and
        // the middle level lerps each value with itself, which passes it unchanged.
        assign b12 = degree_reg ? p2 : p3;
        assign b_a = degree_reg ? q12[c] : q01[c];
        assign b_b = degree_reg ? q23[c] : q12[c];

        bcp_lerp u_q01 (.clk(clk), .en(en), .a(p0), .b(p1), .t(t_reg[0]), .res(q01[c]));
        bcp_lerp u_q12 (.clk(clk), .en(en), .a(p1), .b(b12), .t(t_reg[0]), .res(q12[c]));
        bcp_lerp u_q23 (.clk(clk), .en(en), .a(p2), .b(p3), .t(t_reg[0]), .res(q23[c]));

        bcp_lerp u_la (.clk(clk), .en(en), .a(q01[c]), .b(b_a), .t(t_reg[2]), .res(la[c]));
        bcp_lerp u_lb (.clk(clk), .en(en), .a(q12[c]), .b(b_b), .t(t_reg[2]), .res(lb[c]));

        bcp_lerp u_pt (.clk(clk), .en(en), .a(la[c]), .b(lb[c]), .t(t_reg[4]), .res(pt[c]));
    end

    assign out_valid = valid_reg[PIPE_DEPTH-1];
    assign point_x   = pt[0];
    assign point_y   = pt[1];
    assign point_z   = pt[2];

endmodule

>>> test/tb_bezier_curve_point_core.sv
// Self-checking testbench for bezier_curve_point_core: quadratic and cubic curve points.
// Depends on bcp_pkg and the core RTL; predicts each point by fixed-point de Casteljau lerps.
module tb_bezier_curve_point_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bcp_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          PHASES       = 6;
    localparam int          PER_PHASE    = 100;
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;
    localparam coord_t      COORD_MIN    = coord_t'(-32768);
    localparam coord_t      COORD_MAX    = coord_t'(32767);
    localparam pos_t        POS_MAX      = '1;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PACKED_W-1:0]  cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    pos_t                 position  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    coord_t               point_x;
    coord_t               point_y;
    coord_t               point_z;

    // Local copy of the curve registers, kept in step with every write.
    logic       cur_cubic;
    packed_pt_t cur_start;
    packed_pt_t cur_ctrl1;
    packed_pt_t cur_ctrl2;
    packed_pt_t cur_end;

    point_t pending_points[$];
    int     errors       = 0;
    int     points_sent  = 0;
    int     points_seen  = 0;
    int     cycle_count  = 0;
    int     stall_left   = 0;
    bit     idle_on      = 1'b1;

    bezier_curve_point_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .position  (position),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z)
    );

    always #1 clk = ~clk;

    function automatic longint coord_of(input packed_pt_t pt, input int axis);
        return longint'(coord_t'(pt[axis*COORD_W +: COORD_W]));
    endfunction

    // a + round((b - a) * t / 2^F), rounding half up; >>> on a signed value floors.
    function automatic longint lerp(input longint a, input longint b, input longint t);
        longint prod;
        prod = (b - a) * t + (longint'(1) << (FRAC_W - 1));
        return a + (prod >>> FRAC_W);
    endfunction

    function automatic point_t curve_point(input pos_t pos);
        longint t;
        longint s, c1, c2, e, q01, q12, q23, a, b;
        longint r[3];
        point_t pt;
        t = (pos > POS_ONE) ? longint'(POS_ONE) : longint'(pos);
        for (int axis = 0; axis < NUM_AXES; axis++)
        begin
            s  = coord_of(cur_start, axis);
            c1 = coord_of(cur_ctrl1, axis);
            c2 = coord_of(cur_ctrl2, axis);
            e  = coord_of(cur_end, axis);
            if (cur_cubic)
            begin
                q01 = lerp(s, c1, t);
                q12 = lerp(c1, c2, t);
                q23 = lerp(c2, e, t);
                a   = lerp(q01, q12, t);
                b   = lerp(q12, q23, t);
            end
            else
            begin
                a = lerp(s, c1, t);
                b = lerp(c1, e, t);
            end
            r[axis] = lerp(a, b, t);
        end
        pt.x = coord_t'(r[0]);
        pt.y = coord_t'(r[1]);
        pt.z = coord_t'(r[2]);
        return pt;
    endfunction

    function automatic packed_pt_t pack_point(input coord_t x, input coord_t y, input coord_t z);
        return {z, y, x};
    endfunction

    function automatic coord_t random_coord();
        case ($urandom_range(0, 7))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic pos_t random_position();
        case ($urandom_range(0, 9))
            0:       return pos_t'($urandom_range(int'(POS_ONE) + 1, int'(POS_MAX)));
            1:       return $urandom_range(0, 1) ? POS_ONE : pos_t'(0);
            default: return pos_t'($urandom_range(0, int'(POS_ONE)));
        endcase
    endfunction

    // Called and returning just after a falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [PACKED_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            CFG_DEGREE: cur_cubic = value[0];
            CFG_START:  cur_start = value;
            CFG_CTRL1:  cur_ctrl1 = value;
            CFG_CTRL2:  cur_ctrl2 = value;
            CFG_END:    cur_end   = value;
            default:    ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Offers one position word and returns at the falling edge after it is taken.
    task automatic send_position(input pos_t pos);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid <= 1'b1;
        position <= pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_points.push_back(curve_point(pos));
        points_sent++;
        @(negedge clk);
    endtask

    // Lowers valid and waits until every expected point has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_reset_state();
        send_position('0);
        send_position(POS_ONE);
        drain();
    endtask

    task automatic test_cubic_extremes();
        pos_t positions[7];
        positions = '{'0, pos_t'(1), pos_t'(32768), pos_t'(65535), POS_ONE,
                      POS_ONE + pos_t'(1), POS_MAX};
        write_reg(CFG_START, pack_point(COORD_MIN, COORD_MAX, COORD_MIN));
        write_reg(CFG_CTRL1, pack_point(COORD_MAX, COORD_MIN, COORD_MAX));
        write_reg(CFG_CTRL2, pack_point(COORD_MIN, COORD_MIN, COORD_MAX));
        write_reg(CFG_END, pack_point(COORD_MAX, COORD_MAX, COORD_MIN));
        foreach (positions[i])
            send_position(positions[i]);
        drain();
    endtask

    // The upper bits of the degree word are set and must be ignored; the second
    // control point is moved to show it plays no part in a quadratic curve.
    task automatic test_quadratic();
        write_reg(CFG_DEGREE, {{(PACKED_W-1){1'b1}}, 1'b0});
        write_reg(CFG_CTRL2, pack_point(coord_t'(12345), coord_t'(-777), COORD_MAX));
        write_reg(CFG_START, pack_point(COORD_MAX, COORD_MAX, COORD_MAX));
        write_reg(CFG_CTRL1, pack_point(COORD_MIN, coord_t'(0), coord_t'(-1)));
        write_reg(CFG_END, pack_point(COORD_MAX, COORD_MIN, coord_t'(1)));
        send_position('0);
        send_position(pos_t'(1));
        send_position(pos_t'(21845));
        send_position(pos_t'(65535));
        send_position(POS_ONE);
        send_position(POS_MAX);
        drain();
    endtask

    task automatic test_spare_indexes();
        for (int idx = int'(SPARE_IDX_LO); idx <= int'(SPARE_IDX_HI); idx++)
            write_reg(CFG_IDX_W'(idx), packed_pt_t'({$urandom, $urandom}));
        send_position(pos_t'(16384));
        send_position(pos_t'(49152));
        drain();
    endtask

    task automatic test_random_curves();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            // The last phase runs with both sides streaming flat out.
            idle_on = (phase != PHASES - 1);
            write_reg(CFG_DEGREE, packed_pt_t'({$urandom, $urandom}));
            write_reg(CFG_START, pack_point(random_coord(), random_coord(), random_coord()));
            write_reg(CFG_CTRL1, pack_point(random_coord(), random_coord(), random_coord()));
            write_reg(CFG_CTRL2, pack_point(random_coord(), random_coord(), random_coord()));
            write_reg(CFG_END, pack_point(random_coord(), random_coord(), random_coord()));
            for (int n = 0; n < PER_PHASE; n++)
                send_position(random_position());
            drain();
        end
    endtask

    // Output back-pressure in bursts, driven on the falling edge.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 17);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && out_valid && out_ready)
        begin
            points_seen++;
            if (pending_points.size() == 0)
            begin
                $error("point word with no expected point waiting: (%0d, %0d, %0d)",
                       point_x, point_y, point_z);
                errors++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (point_x !== want.x)
                begin
                    $error("point_x: expected %0d, got %0d", want.x, point_x);
                    errors++;
                end
                if (point_y !== want.y)
                begin
                    $error("point_y: expected %0d, got %0d", want.y, point_y);
                    errors++;
                end
                if (point_z !== want.z)
                begin
                    $error("point_z: expected %0d, got %0d", want.z, point_z);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out with %0d points still expected.", pending_points.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        cur_cubic = 1'b1;
        cur_start = '0;
        cur_ctrl1 = '0;
        cur_ctrl2 = '0;
        cur_end   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_cubic_extremes();
        test_quadratic();
        test_spare_indexes();
        test_random_curves();

        // Anything the core emits after this point has no expectation to match.
        repeat (4 * PIPE_DEPTH) @(negedge clk);
        if (pending_points.size() != 0)
        begin
            $error("%0d expected points never arrived", pending_points.size());
            errors++;
        end

        $display("Sent %0d positions and checked %0d points across quadratic and cubic curves,",
                 points_sent, points_seen);
        $display("including saturated positions, extreme control points and ignored writes.");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
rtl/bcp_pkg.sv
rtl/bcp_lerp.sv
rtl/bezier_curve_point_core.sv
test/tb_bezier_curve_point_core.sv
